// ===== src/ndt_pkg.sv =====
`default_nettype none

package ndt_pkg;

	// fixed field widths of the stream payload
	localparam int NAME_W     = 64;
	localparam int SECTOR_W   = 12;
	localparam int INDEX_W    = 6;
	localparam int KIND_W     = 2;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 24;

	// request operations
	localparam logic [KIND_W-1:0] OP_FIND   = 2'd0;
	localparam logic [KIND_W-1:0] OP_ADD    = 2'd1;
	localparam logic [KIND_W-1:0] OP_REMOVE = 2'd2;

	// result status codes
	localparam logic [KIND_W-1:0] STS_OK        = 2'd0;
	localparam logic [KIND_W-1:0] STS_NOT_FOUND = 2'd1;
	localparam logic [KIND_W-1:0] STS_PRESENT   = 2'd2;
	localparam logic [KIND_W-1:0] STS_FULL      = 2'd3;

	// request sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_SEL,
		S_RES
	} state_t;

	// strobes broadcast from the sequencer to every cell
	typedef struct packed {
		logic cmp;
		logic sel;
		logic wr;
		logic clr;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/name_keyed_directory_table_unit.sv =====
`default_nettype none

// Directory table of ENTRIES name-keyed entries held in a row of cells, one
// entry per cell. Each request on the slave stream (find, add or remove)
// gives exactly one result on the master stream. A request is taken when
// the unit is idle; it then passes a compare state that matches the name
// in every cell, a select state in which the lowest matching and lowest
// free cell claim the request along the cell chain, and a resolve state
// that sets the status and updates the chosen cell, before the unit is
// idle again to take a new request. The result waits in an output register,
// and a following request proceeds up to its resolve state while that result
// is still untaken. Names are cut at their first zero byte and at NAME_CHARS
// bytes before they are stored or compared. All entries are free after reset.
module name_keyed_directory_table_unit #(
	parameter int ENTRIES     = 64,
	parameter int NAME_CHARS  = 8,
	parameter int SECTOR_BITS = 12
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// name[63:0], sector[75:64], is_directory[76], zero[79:77]
	input  wire [ndt_pkg::IN_DATA_W-1:0]      s_tdata,
	// req_type[1:0]
	input  wire [ndt_pkg::KIND_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// index[5:0], found_sector[17:6], zero[23:18]
	output logic [ndt_pkg::OUT_DATA_W-1:0]    m_tdata,
	// status[1:0]
	output logic [ndt_pkg::KIND_W-1:0]        m_tuser
);

	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int IDX_X_W = IDX_W + ndt_pkg::INDEX_W;
	localparam int SEC_X_W = SECTOR_BITS + ndt_pkg::SECTOR_W;

	ndt_pkg::state_t              state_q;
	ndt_pkg::state_t              state_nxt;
	ndt_pkg::cell_ctl_t           ctl;

	logic [ndt_pkg::NAME_W-1:0]   in_canon;
	logic                         name_alive;
	logic [SEC_X_W-1:0]           in_sec_ext;
	logic                         s_xfer;
	logic                         res_go;

	logic [ndt_pkg::KIND_W-1:0]   req_op_q;
	logic [ndt_pkg::NAME_W-1:0]   req_name_q;
	logic [SECTOR_BITS-1:0]       req_sector_q;
	logic                         req_dir_q;

	logic                         any_hit;
	logic                         any_free;
	logic [IDX_W-1:0]             hit_idx;
	logic [IDX_W-1:0]             free_idx;
	logic [SECTOR_BITS-1:0]       hit_sector;

	logic [ndt_pkg::KIND_W-1:0]   res_status;
	logic [IDX_W-1:0]             res_idx;
	logic [SECTOR_BITS-1:0]       res_sector;
	logic                         res_wr;
	logic                         res_clr;
	logic [IDX_X_W-1:0]           res_idx_ext;
	logic [SEC_X_W-1:0]           res_sec_ext;

	logic                         m_tvalid_q;
	logic [ndt_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic [ndt_pkg::KIND_W-1:0]   m_tuser_q;

	assign s_xfer = s_tvalid && s_tready;
	assign res_go = (state_q == ndt_pkg::S_RES) && (!m_tvalid_q || m_tready);

	// canonical name: cut at the first zero byte and at NAME_CHARS
	always_comb begin
		in_canon   = '0;
		name_alive = 1'b1;
		for (int b = 0; b < 8; b++) begin
			if (name_alive && (b < NAME_CHARS) && (s_tdata[8*b +: 8] != 8'd0)) begin
				in_canon[8*b +: 8] = s_tdata[8*b +: 8];
			end else begin
				name_alive = 1'b0;
			end
		end
	end

	assign in_sec_ext = SEC_X_W'(s_tdata[75:64]);

	// request register
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			req_op_q     <= s_tuser;
			req_name_q   <= in_canon;
			req_sector_q <= in_sec_ext[SECTOR_BITS-1:0];
			req_dir_q    <= s_tdata[76];
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ndt_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ndt_pkg::S_IDLE: begin
				if (s_xfer) state_nxt = ndt_pkg::S_CMP;
			end
			ndt_pkg::S_CMP: begin
				state_nxt = ndt_pkg::S_SEL;
			end
			ndt_pkg::S_SEL: begin
				state_nxt = ndt_pkg::S_RES;
			end
			ndt_pkg::S_RES: begin
				if (res_go) state_nxt = ndt_pkg::S_IDLE;
			end
			default: begin
				state_nxt = ndt_pkg::S_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = (state_q == ndt_pkg::S_IDLE);
		ctl.cmp  = (state_q == ndt_pkg::S_CMP);
		ctl.sel  = (state_q == ndt_pkg::S_SEL);
		ctl.wr   = res_go && res_wr;
		ctl.clr  = res_go && res_clr;
	end

	ndt_row #(
		.ENTRIES    (ENTRIES),
		.SECTOR_BITS(SECTOR_BITS),
		.IDX_W      (IDX_W)
	) u_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.req_name  (req_name_q),
		.req_sector(req_sector_q),
		.req_dir   (req_dir_q),
		.any_hit   (any_hit),
		.any_free  (any_free),
		.hit_idx   (hit_idx),
		.free_idx  (free_idx),
		.hit_sector(hit_sector)
	);

	// resolve status and table update
	always_comb begin
		res_status = ndt_pkg::STS_NOT_FOUND;
		res_idx    = '0;
		res_sector = '0;
		res_wr     = 1'b0;
		res_clr    = 1'b0;
		unique case (req_op_q)
			ndt_pkg::OP_FIND: begin
				if (any_hit) begin
					res_status = ndt_pkg::STS_OK;
					res_idx    = hit_idx;
					res_sector = hit_sector;
				end
			end
			ndt_pkg::OP_ADD: begin
				if (any_hit) begin
					res_status = ndt_pkg::STS_PRESENT;
				end else if (any_free) begin
					res_status = ndt_pkg::STS_OK;
					res_idx    = free_idx;
					res_wr     = 1'b1;
				end else begin
					res_status = ndt_pkg::STS_FULL;
				end
			end
			ndt_pkg::OP_REMOVE: begin
				if (any_hit) begin
					res_status = ndt_pkg::STS_OK;
					res_idx    = hit_idx;
					res_clr    = 1'b1;
				end
			end
			default: begin
				res_status = ndt_pkg::STS_NOT_FOUND;
			end
		endcase
	end

	assign res_idx_ext = IDX_X_W'(res_idx);
	assign res_sec_ext = SEC_X_W'(res_sector);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (res_go) begin
			m_tuser_q <= res_status;
			m_tdata_q <= {6'd0, res_sec_ext[ndt_pkg::SECTOR_W-1:0],
				res_idx_ext[ndt_pkg::INDEX_W-1:0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

// ===== src/ndt_cell.sv =====
`default_nettype none

module ndt_cell #(
	parameter int SECTOR_BITS = 12
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  ndt_pkg::cell_ctl_t            ctl,
	input  wire [ndt_pkg::NAME_W-1:0]     req_name,
	input  wire [SECTOR_BITS-1:0]         req_sector,
	input  wire                           req_dir,
	input  wire                           hit_in,
	input  wire                           free_in,
	output logic                          hit_out,
	output logic                          free_out,
	output logic                          sel_hit,
	output logic                          sel_free,
	output logic [SECTOR_BITS-1:0]        sector
);

	logic                         valid_q;
	logic [ndt_pkg::NAME_W-1:0]   name_q;
	logic [SECTOR_BITS-1:0]       sector_q;
	logic                         dir_q;
	logic                         hit_q;
	logic                         free_q;
	logic                         sel_hit_q;
	logic                         sel_free_q;

	// valid mark, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.wr && sel_free_q) begin
			valid_q <= 1'b1;
		end else if (ctl.clr && sel_hit_q) begin
			valid_q <= 1'b0;
		end
	end

	// entry contents, written by an add into this cell
	always_ff @(posedge clk) begin
		if (ctl.wr && sel_free_q) begin
			name_q   <= req_name;
			sector_q <= req_sector;
			dir_q    <= req_dir;
		end
	end

	// local match and free flags
	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			hit_q  <= valid_q && (name_q == req_name);
			free_q <= !valid_q;
		end
	end

	// pass the taken marks on to the next cell
	assign hit_out  = hit_in | hit_q;
	assign free_out = free_in | free_q;

	// this cell wins when no lower cell has already claimed the flag
	always_ff @(posedge clk) begin
		if (ctl.sel) begin
			sel_hit_q  <= hit_q && !hit_in;
			sel_free_q <= free_q && !free_in;
		end
	end

	assign sel_hit  = sel_hit_q;
	assign sel_free = sel_free_q;
	assign sector   = sector_q;

endmodule

`default_nettype wire

// ===== src/ndt_row.sv =====
`default_nettype none

module ndt_row #(
	parameter int ENTRIES     = 64,
	parameter int SECTOR_BITS = 12,
	parameter int IDX_W       = 6
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  ndt_pkg::cell_ctl_t            ctl,
	input  wire [ndt_pkg::NAME_W-1:0]     req_name,
	input  wire [SECTOR_BITS-1:0]         req_sector,
	input  wire                           req_dir,
	output logic                          any_hit,
	output logic                          any_free,
	output logic [IDX_W-1:0]              hit_idx,
	output logic [IDX_W-1:0]              free_idx,
	output logic [SECTOR_BITS-1:0]        hit_sector
);

	logic [ENTRIES:0]             hit_c;
	logic [ENTRIES:0]             free_c;
	logic [ENTRIES-1:0]           sel_hit;
	logic [ENTRIES-1:0]           sel_free;
	logic [SECTOR_BITS-1:0]       cell_sector [ENTRIES];

	assign hit_c[0]  = 1'b0;
	assign free_c[0] = 1'b0;

	// row of entry cells, lowest index first in the chain
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		ndt_cell #(
			.SECTOR_BITS(SECTOR_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.req_name  (req_name),
			.req_sector(req_sector),
			.req_dir   (req_dir),
			.hit_in    (hit_c[i]),
			.free_in   (free_c[i]),
			.hit_out   (hit_c[i+1]),
			.free_out  (free_c[i+1]),
			.sel_hit   (sel_hit[i]),
			.sel_free  (sel_free[i]),
			.sector    (cell_sector[i])
		);
	end

	assign any_hit  = |sel_hit;
	assign any_free = |sel_free;

	// encode the one-hot winners and pick the matching sector
	always_comb begin
		hit_idx    = '0;
		free_idx   = '0;
		hit_sector = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (sel_hit[i]) begin
				hit_idx    = hit_idx | IDX_W'(i);
				hit_sector = hit_sector | cell_sector[i];
			end
			if (sel_free[i]) begin
				free_idx = free_idx | IDX_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/ndt_checker.sv =====
`default_nettype none

module ndt_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [79:0] s_tdata,
	input wire [1:0]  s_tuser,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata,
	input wire [1:0]  m_tuser
);

	// one request at a time: no transfer right after a transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while a request is in progress");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

	// failures report entry zero
	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != ndt_pkg::STS_OK)) |-> (m_tdata[5:0] == 6'd0))
		else $error("failed request reports a non-zero index");

	// failures report no sector
	a_fail_sector: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != ndt_pkg::STS_OK)) |-> (m_tdata[17:6] == 12'd0))
		else $error("failed request reports a sector");

endmodule

bind name_keyed_directory_table_unit ndt_checker u_ndt_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

`default_nettype wire
